[sv/arsc_pkg.sv]
// Shared constants, types and control bundles for the add-rotate-xor stream cipher.
`timescale 1ns / 1ps

package arsc_pkg;

    localparam int KEYSTREAM_BYTES = 64;
    localparam int MIX_ROUNDS      = 10;

    // One round is split into four phases, one per cycle
    localparam int MIX_PHASES = 4;
    localparam int MIX_STEPS  = MIX_PHASES * MIX_ROUNDS;
    localparam int STEP_W     = $clog2(MIX_STEPS);
    localparam int PHASE_W    = $clog2(MIX_PHASES);

    // Byte position counts up to KEYSTREAM_BYTES, which marks an exhausted block
    localparam int POS_W = $clog2(KEYSTREAM_BYTES) + 1;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] CONST_A = 32'hd243_6335;
    localparam logic [31:0] CONST_B = 32'hb205_2534;

    typedef logic [31:0]      word_t;
    typedef word_t [15:0]     blk_t;
    typedef logic [7:0]       byte_t;

    // Cipher state loaded from the all-zero reset registers: only words 10 and 11 are set
    localparam blk_t STATE_RESET = {128'd0, CONST_B, CONST_A, 320'd0};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_NONCE0 = 3'd4,
        REG_NONCE1 = 3'd5,
        REG_NONCE2 = 3'd6,
        REG_CTR    = 3'd7
    } cfg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic                fast_take;  // accept item, keystream byte ready
        logic                slow_take;  // accept item, new block needed first
        logic                load_block; // copy state into keystream, step counter
        logic                mix_step;   // apply one phase of the mixture
        logic [PHASE_W-1:0]  mix_phase;
        logic                emit;       // deliver the held item from a fresh block
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_block; // offered item restarts or block is used up
        logic out_free;   // output register can take a result this cycle
    } dp_stat_t;

endpackage

[sv/arsc_dp.sv]
// Datapath: configuration registers, cipher state, keystream block and output register.
`timescale 1ns / 1ps

module arsc_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [arsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                        in_byte,
    input  logic                              in_restart,
    output logic [7:0]                        out_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    input  arsc_pkg::dp_cmd_t                 cmd,
    output arsc_pkg::dp_stat_t                stat
);
    import arsc_pkg::*;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0] nonce0_reg, nonce1_reg;
    logic [31:0] nonce2_reg, ctr_reg;

    blk_t             state_reg, state_next;
    blk_t             ks_reg, ks_next;
    blk_t             load_val, src_blk, mixed;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             restart_pend_reg;
    byte_t            byte_pend_reg;
    logic             out_valid_reg, out_valid_next;
    byte_t            out_data_reg, out_data_next;
    word_t            ks_word;
    byte_t            ks_byte;

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One quarter of a mixing round; phases run in order within a round
    function automatic blk_t mix_phase_f(blk_t s_in, logic [PHASE_W-1:0] ph);
        blk_t s;
        s = s_in;
        case (ph)
            2'd0:
            begin
                s[0]  = s[0] + rotl(s[5], 3);
                s[5]  = s[5] ^ rotl(s[10], 5);
                s[10] = s[10] + rotl(s[15], 7);
                s[15] = s[15] ^ s[0];
                s[0]  = s[0] ^ ((s[15] - s[14]) ^ s[13]);
            end
            2'd1:
            begin
                s[4]  = s[4] + rotl(s[9], 11);
                s[9]  = s[9] ^ rotl(s[14], 13);
                s[14] = s[14] + rotl(s[3], 17);
                s[3]  = s[3] ^ s[4];
                s[1]  = s[1] ^ ((s[12] ^ s[11]) - s[10]);
            end
            2'd2:
            begin
                s[8]  = s[8] ^ rotl(s[13], 19);
                s[13] = s[13] + rotl(s[2], 23);
                s[2]  = s[2] ^ rotl(s[7], 29);
                s[7]  = s[7] + s[8];
                s[2]  = s[2] ^ ((s[9] - s[8]) ^ s[7]);
            end
            default:
            begin
                s[12] = s[12] ^ rotl(s[1], 31);
                s[1]  = s[1] + rotl(s[6], 1);
                s[6]  = s[6] ^ rotl(s[11], 2);
                s[11] = s[11] + s[12];
                s[3]  = s[3] ^ ((s[6] ^ s[5]) - s[4]);
            end
        endcase
        return s;
    endfunction

    // Capture configuration writes; unused upper bits of the short registers drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            nonce0_reg <= '0;
            nonce1_reg <= '0;
            nonce2_reg <= '0;
            ctr_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_KEY0:   key0_reg   <= cfg_data;
                REG_KEY1:   key1_reg   <= cfg_data;
                REG_KEY2:   key2_reg   <= cfg_data;
                REG_KEY3:   key3_reg   <= cfg_data;
                REG_NONCE0: nonce0_reg <= cfg_data;
                REG_NONCE1: nonce1_reg <= cfg_data;
                REG_NONCE2: nonce2_reg <= cfg_data[31:0];
                REG_CTR:    ctr_reg    <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // Build the fresh state from the configuration registers
    always_comb
    begin
        load_val[0]  = key0_reg[31:0];
        load_val[1]  = key0_reg[63:32];
        load_val[2]  = key1_reg[31:0];
        load_val[3]  = key1_reg[63:32];
        load_val[4]  = key2_reg[31:0];
        load_val[5]  = key2_reg[63:32];
        load_val[6]  = key3_reg[31:0];
        load_val[7]  = key3_reg[63:32];
        load_val[8]  = nonce0_reg[31:0];
        load_val[9]  = nonce0_reg[63:32];
        load_val[10] = CONST_A;
        load_val[11] = CONST_B;
        load_val[12] = nonce1_reg[31:0];
        load_val[13] = nonce1_reg[63:32];
        load_val[14] = nonce2_reg;
        load_val[15] = ctr_reg;
    end

    // Pick the current keystream byte, little-endian within each word
    assign ks_word = ks_reg[pos_reg[POS_W-2:2]];
    assign ks_byte = byte_t'(ks_word >> {pos_reg[1:0], 3'b000});

    assign src_blk = restart_pend_reg ? load_val : state_reg;
    assign mixed   = mix_phase_f(ks_reg, cmd.mix_phase);

    // Next-state logic for state, keystream, position and output register
    always_comb
    begin
        state_next     = state_reg;
        ks_next        = ks_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.fast_take)
        begin
            out_data_next  = in_byte ^ ks_byte;
            out_valid_next = 1'b1;
            pos_next       = pos_reg + POS_W'(1);
        end

        if (cmd.load_block)
        begin
            ks_next        = src_blk;
            state_next     = src_blk;
            // Word 14 steps only when word 15 was zero before its increment
            if (src_blk[15] == '0)
            begin
                state_next[14] = src_blk[14] + 32'd1;
            end
            state_next[15] = src_blk[15] + 32'd1;
        end

        if (cmd.mix_step)
        begin
            ks_next = mixed;
        end

        if (cmd.emit)
        begin
            out_data_next  = byte_pend_reg ^ ks_reg[0][7:0];
            out_valid_next = 1'b1;
            pos_next       = POS_W'(1);
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= STATE_RESET;
            pos_reg          <= POS_W'(KEYSTREAM_BYTES);
            restart_pend_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cmd.slow_take)
            begin
                restart_pend_reg <= in_restart;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ks_reg       <= ks_next;
        out_data_reg <= out_data_next;
        if (cmd.slow_take)
        begin
            byte_pend_reg <= in_byte;
        end
    end

    assign out_byte        = out_data_reg;
    assign out_valid       = out_valid_reg;
    assign stat.need_block = in_restart || pos_reg[POS_W-1];
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

[sv/arsc_ctrl.sv]
// Controller: input handshake and sequencing of block load, mixing and delivery.
`timescale 1ns / 1ps

module arsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  arsc_pkg::dp_stat_t  stat,
    output arsc_pkg::dp_cmd_t   cmd
);
    import arsc_pkg::*;

    typedef enum logic [3:0] {
        S_READY = 4'b0001,
        S_LOAD  = 4'b0010,
        S_MIX   = 4'b0100,
        S_EMIT  = 4'b1000
    } fsm_t;

    fsm_t              fsm_reg, fsm_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              take;
    logic              last_step;

    assign in_ready  = (fsm_reg == S_READY) && stat.out_free;
    assign take      = in_ready && in_valid;
    assign last_step = (step_reg == STEP_W'(MIX_STEPS - 1));

    // Sequence one block: load, all mixing phases, then deliver the held item
    always_comb
    begin
        fsm_next  = fsm_reg;
        step_next = step_reg;
        case (fsm_reg)
            S_READY:
            begin
                if (take && stat.need_block)
                begin
                    fsm_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                fsm_next  = S_MIX;
                step_next = '0;
            end
            S_MIX:
            begin
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    fsm_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                fsm_next = S_READY;
            end
            default:
            begin
                fsm_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg  <= S_READY;
            step_reg <= '0;
        end
        else
        begin
            fsm_reg  <= fsm_next;
            step_reg <= step_next;
        end
    end

    // Drive datapath commands
    assign cmd.fast_take  = take && !stat.need_block;
    assign cmd.slow_take  = take && stat.need_block;
    assign cmd.load_block = (fsm_reg == S_LOAD);
    assign cmd.mix_step   = (fsm_reg == S_MIX);
    assign cmd.mix_phase  = step_reg[PHASE_W-1:0];
    assign cmd.emit       = (fsm_reg == S_EMIT);

endmodule

[sv/add_rotate_xor_stream_cipher_core.sv]
// Top level of the add-rotate-xor byte-stream cipher.
//
//  Channel   Direction  Handshake                 Content
//  s_axis    in         s_axis_tvalid/tready      tdata: data_byte; tuser: restart
//  m_axis    out        m_axis_tvalid/tready      tdata: out_byte
//  cfg       in         cfg_we (no wait)          cfg_index selects register, cfg_data
//
// Within a keystream block, while the output is not stalled, one item is accepted per cycle and its result
// appears in the output register on the next edge.
// An item that opens a new block (block used up, or restart set) holds the
// input through a load state, four mixing phases per round through one
// shared round unit, and a delivery state.
// After reset the state holds the reset register values and the first item
// opens a new block. A stalled output holds its result and blocks new input.
`timescale 1ns / 1ps

module add_rotate_xor_stream_cipher_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [arsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata   // [7:0] out_byte
);
    import arsc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    arsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    arsc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_byte    (s_axis_tdata),
        .in_restart (s_axis_tuser),
        .out_byte   (m_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

[test/tb_add_rotate_xor_stream_cipher_core.sv]
// Self-checking testbench for the add-rotate-xor stream cipher core.
`timescale 1ns / 1ps

module tb_add_rotate_xor_stream_cipher_core;

    import arsc_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 4 * MIX_ROUNDS + 20;
    localparam int DIR_ROWS    = 16;

    // Key/nonce settings applied between phases
    typedef enum int {
        SET_ZERO,
        SET_ONES,
        SET_CTR_WRAP,
        SET_RANDOM,
        SET_PARTIAL
    } key_setting_t;

    // One directed item, restart flag above the data byte
    typedef struct packed {
        logic  restart;
        byte_t data;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;

    // Cipher model: register copies, running state, keystream and position
    logic [63:0] key_regs [8];
    blk_t        ciph_state;
    blk_t        ks_blk;
    logic [6:0]  ks_pos;

    byte_t     exp_out_q [$];
    stim_row_t dir_rows [DIR_ROWS];

    int  err_count;
    int  items_sent;
    int  results_checked;
    int  restarts_sent;
    int  blocks_opened;
    int  phases_run;
    int  cycle_count;
    bit  tx_calm;
    bit  hold_done;

    add_rotate_xor_stream_cipher_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),  // [0] restart
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // [7:0] out_byte
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic word_t rotl32(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Apply one pass of the add-rotate-xor mixture
    function automatic blk_t mix_round(blk_t s);
        s[0]  = s[0] + rotl32(s[5], 3);
        s[5]  = s[5] ^ rotl32(s[10], 5);
        s[10] = s[10] + rotl32(s[15], 7);
        s[15] = s[15] ^ s[0];
        s[0]  = s[0] ^ ((s[15] - s[14]) ^ s[13]);

        s[4]  = s[4] + rotl32(s[9], 11);
        s[9]  = s[9] ^ rotl32(s[14], 13);
        s[14] = s[14] + rotl32(s[3], 17);
        s[3]  = s[3] ^ s[4];
        s[1]  = s[1] ^ ((s[12] ^ s[11]) - s[10]);

        s[8]  = s[8] ^ rotl32(s[13], 19);
        s[13] = s[13] + rotl32(s[2], 23);
        s[2]  = s[2] ^ rotl32(s[7], 29);
        s[7]  = s[7] + s[8];
        s[2]  = s[2] ^ ((s[9] - s[8]) ^ s[7]);

        s[12] = s[12] ^ rotl32(s[1], 31);
        s[1]  = s[1] + rotl32(s[6], 1);
        s[6]  = s[6] ^ rotl32(s[11], 2);
        s[11] = s[11] + s[12];
        s[3]  = s[3] ^ ((s[6] ^ s[5]) - s[4]);
        return s;
    endfunction

    // Load the running state from the register copies
    function automatic void load_cipher_state();
        for (int i = 0; i < 4; i++)
        begin
            ciph_state[2 * i]     = key_regs[i][31:0];
            ciph_state[2 * i + 1] = key_regs[i][63:32];
        end
        ciph_state[8]  = key_regs[REG_NONCE0][31:0];
        ciph_state[9]  = key_regs[REG_NONCE0][63:32];
        ciph_state[10] = CONST_A;
        ciph_state[11] = CONST_B;
        ciph_state[12] = key_regs[REG_NONCE1][31:0];
        ciph_state[13] = key_regs[REG_NONCE1][63:32];
        ciph_state[14] = key_regs[REG_NONCE2][31:0];
        ciph_state[15] = key_regs[REG_CTR][31:0];
    endfunction

    // Mix a copy of the state into a new keystream block, then step the counter
    function automatic void refill_keystream();
        ks_blk = ciph_state;
        for (int r = 0; r < MIX_ROUNDS; r++)
        begin
            ks_blk = mix_round(ks_blk);
        end
        if (ciph_state[15] == 32'd0)
        begin
            ciph_state[14] = ciph_state[14] + 32'd1;
        end
        ciph_state[15] = ciph_state[15] + 32'd1;
        blocks_opened++;
    endfunction

    // Advance the model by one item and return the expected output byte
    function automatic byte_t predict_out_byte(byte_t din, logic restart);
        word_t w;
        byte_t ks;
        if (restart)
        begin
            load_cipher_state();
            ks_pos = 7'(KEYSTREAM_BYTES);
        end
        if (ks_pos >= 7'(KEYSTREAM_BYTES))
        begin
            refill_keystream();
            ks_pos = 7'd0;
        end
        w      = ks_blk[ks_pos[5:2]];
        ks     = byte_t'(w >> (8 * ks_pos[1:0]));
        ks_pos = ks_pos + 7'd1;
        return din ^ ks;
    endfunction

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at output %0d: %s got 0x%02h want 0x%02h (t=%0t)",
                 results_checked, what, got, want, $realtime);
        err_count++;
    endtask

    // Drive one register write and mirror it into the model
    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_NONCE2 || idx == REG_CTR)
            key_regs[idx] = {32'd0, val[31:0]};
        else
            key_regs[idx] = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Write all or some key/nonce/ctr registers; narrow extra bits random or ones
    task automatic apply_setting(key_setting_t kind);
        case (kind)
            SET_ZERO:
            begin
                write_reg(REG_KEY0, 64'd0);
                write_reg(REG_KEY1, 64'd0);
                write_reg(REG_KEY2, 64'd0);
                write_reg(REG_KEY3, 64'd0);
                write_reg(REG_NONCE0, 64'd0);
                write_reg(REG_NONCE1, 64'd0);
                write_reg(REG_NONCE2, {$urandom, 32'd0});
                write_reg(REG_CTR, {$urandom, 32'd0});
            end
            SET_ONES:
            begin
                write_reg(REG_KEY0, '1);
                write_reg(REG_KEY1, '1);
                write_reg(REG_KEY2, '1);
                write_reg(REG_KEY3, '1);
                write_reg(REG_NONCE0, '1);
                write_reg(REG_NONCE1, '1);
                write_reg(REG_NONCE2, '1);
                write_reg(REG_CTR, '1);
            end
            SET_CTR_WRAP:
            begin
                write_reg(REG_KEY0, rand64());
                write_reg(REG_KEY1, rand64());
                write_reg(REG_KEY2, rand64());
                write_reg(REG_KEY3, rand64());
                write_reg(REG_NONCE0, rand64());
                write_reg(REG_NONCE1, rand64());
                write_reg(REG_NONCE2, {$urandom, 32'hffff_ffff});
                write_reg(REG_CTR, {$urandom, 32'hffff_fffe});
            end
            SET_PARTIAL:
            begin
                // Touch only some registers; the rest keep the previous setting
                write_reg(REG_KEY2, rand64());
                write_reg(REG_NONCE1, rand64());
                write_reg(REG_CTR, rand64());
            end
            default:
            begin
                write_reg(REG_KEY0, rand64());
                write_reg(REG_KEY1, rand64());
                write_reg(REG_KEY2, rand64());
                write_reg(REG_KEY3, rand64());
                write_reg(REG_NONCE0, rand64());
                write_reg(REG_NONCE1, rand64());
                write_reg(REG_NONCE2, rand64());
                write_reg(REG_CTR, rand64());
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one item after an optional gap and predict its output on acceptance
    task automatic send_item(byte_t data, logic restart);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        exp_out_q.push_back(predict_out_byte(data, restart));
        items_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // Drop valid and hold until every expected output has come back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (exp_out_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Check each accepted output against the oldest prediction
    always @(posedge clk)
    begin
        byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (exp_out_q.size() == 0)
            begin
                report_mismatch("unexpected out_byte", m_axis_tdata, 0);
            end
            else
            begin
                want = exp_out_q.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch("out_byte", m_axis_tdata, want);
            end
            results_checked++;
        end
    end

    // Output ready: random stalls, calm stretches, and one long hold-off
    initial
    begin
        int rx_gap;
        int rx_cycles;
        bit rx_calm;
        rx_gap    = 0;
        rx_cycles = 0;
        rx_calm   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            rx_cycles++;
            if (rx_cycles % 300 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && results_checked >= 500)
            begin
                hold_done = 1'b1;
                rx_gap    = LONG_HOLD;
            end
            if (rx_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_calm)
                    rx_gap = pick_gap();
            end
        end
    end

    // End the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d outputs pending",
                 cycle_count, exp_out_q.size());
        $display("Verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        key_setting_t kind;
        int           phase_len;
        int           restart_odds;
        logic         rst_bit;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_KEY0;
        cfg_data        = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        m_axis_tready   = 1'b0;
        err_count       = 0;
        items_sent      = 0;
        results_checked = 0;
        restarts_sent   = 0;
        blocks_opened   = 0;
        phases_run      = 0;
        tx_calm         = 1'b0;
        hold_done       = 1'b0;

        // Model reset: zero registers, state loaded from them, block used up
        for (int i = 0; i < 8; i++)
            key_regs[i] = 64'd0;
        ks_blk = '0;
        load_cipher_state();
        ks_pos = 7'(KEYSTREAM_BYTES);

        // First item opens a block from reset values; then data extremes and restarts
        dir_rows = '{
            '{1'b0, 8'h00}, '{1'b0, 8'hff}, '{1'b0, 8'h55}, '{1'b0, 8'haa},
            '{1'b0, 8'h01}, '{1'b0, 8'h80}, '{1'b1, 8'h00}, '{1'b1, 8'hff},
            '{1'b1, 8'h5a}, '{1'b0, 8'h7f}, '{1'b0, 8'hfe}, '{1'b0, 8'h00},
            '{1'b1, 8'hff}, '{1'b0, 8'hff}, '{1'b0, 8'h0f}, '{1'b0, 8'hf0}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, checked against the model
        tx_calm = 1'b1;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == DIR_ROWS / 2)
                tx_calm = 1'b0;
            send_item(dir_rows[i].data, dir_rows[i].restart);
        end
        phases_run++;

        // Random phases, each under a fresh setting written while idle
        while (items_sent < ITEM_TARGET)
        begin
            wait_drained();
            case (phases_run)
                1:       kind = SET_ONES;
                2:       kind = SET_ZERO;
                3:       kind = SET_CTR_WRAP;
                6:       kind = SET_PARTIAL;
                default: kind = ($urandom_range(0, 4) == 0) ? SET_PARTIAL : SET_RANDOM;
            endcase
            apply_setting(kind);

            phase_len    = $urandom_range(120, 200);
            tx_calm      = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       restart_odds = 16;
                1:       restart_odds = 48;
                default: restart_odds = 200;
            endcase
            // Counter wrap needs several blocks with no restart in between
            if (kind == SET_ONES || kind == SET_CTR_WRAP)
            begin
                restart_odds = 0;
                phase_len    = 200;
            end

            for (int n = 0; n < phase_len && items_sent < ITEM_TARGET; n++)
            begin
                if (n == 0)
                    rst_bit = (kind == SET_ONES || kind == SET_CTR_WRAP)
                              ? 1'b1 : logic'($urandom_range(0, 1));
                else if (restart_odds == 0)
                    rst_bit = 1'b0;
                else
                    rst_bit = ($urandom_range(0, restart_odds - 1) == 0);
                send_item(byte_t'($urandom_range(0, 255)), rst_bit);
            end
            phases_run++;
        end

        // Drain, then allow for a late extra output
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d bytes over %0d settings: %0d restarts, %0d keystream blocks,",
                 items_sent, phases_run, restarts_sent, blocks_opened);
        $display("%0d outputs compared, %0d mismatches, %0d cycles",
                 results_checked, err_count, cycle_count);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
